### hw/rtl/content_length_message_deframer_top_assert.svh
// Assertion macros for the Content-Length deframer.
// Used by the top level; needs signals clk and rst_n in the including scope.
`ifndef CONTENT_LENGTH_MESSAGE_DEFRAMER_TOP_ASSERT_SVH
`define CONTENT_LENGTH_MESSAGE_DEFRAMER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CLMD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clmd assertion failed");

// Next-cycle implication, checked outside reset.
`define CLMD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clmd assertion failed");

`endif

### hw/rtl/clmd_pkg.sv
// Shared constants, types and helpers of the Content-Length deframer.
// No dependencies; used by clmd_value and the top level.
`timescale 1ns / 1ps

package clmd_pkg;

  localparam int LENGTH_BITS = 31;
  localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = {LENGTH_BITS{1'b1}};

  localparam int KEY_LEN  = 16;
  localparam int MARK_LEN = 4;

  localparam logic [7:0] KEY_TEXT [KEY_LEN] = '{
    8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
    8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A, 8'h20
  };
  localparam logic [7:0] MARK_TEXT [MARK_LEN] = '{8'h0D, 8'h0A, 8'h0D, 8'h0A};

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Value parser phases.
  localparam logic [2:0] PH_LEAD   = 3'd0;
  localparam logic [2:0] PH_SIGN   = 3'd1;
  localparam logic [2:0] PH_DIGITS = 3'd2;
  localparam logic [2:0] PH_TRAIL  = 3'd3;
  localparam logic [2:0] PH_BAD    = 3'd4;

  typedef struct packed {
    logic [2:0]             phase;
    logic                   negative;
    logic [LENGTH_BITS-1:0] accum;
  } val_t;

  typedef struct packed {
    logic [30:0] largest_body;
    logic        framing_error;
    logic        end_of_message;
    logic        is_body;
    logic [7:0]  out_byte;
  } res_t;

  function automatic logic is_blank(input logic [7:0] b);
    is_blank = (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) ||
               (b == 8'h0B) || (b == 8'h0C) || (b == 8'h0D);
  endfunction

endpackage

### hw/rtl/clmd_value.sv
// Next-state logic of the decimal length parser, one header byte per call.
// Depends on clmd_pkg.
`timescale 1ns / 1ps

module clmd_value (
  input  logic [7:0]    in_byte,
  input  clmd_pkg::val_t cur,
  output clmd_pkg::val_t nxt
);

  logic                            dig;
  logic [3:0]                      d;
  logic [clmd_pkg::LENGTH_BITS+3:0] wide;
  logic [clmd_pkg::LENGTH_BITS+3:0] a_ext;

  assign dig   = (in_byte >= clmd_pkg::CHAR_ZERO) && (in_byte <= clmd_pkg::CHAR_NINE);
  assign d     = dig ? 4'(in_byte - clmd_pkg::CHAR_ZERO) : 4'd0;
  assign a_ext = {4'd0, cur.accum};
  // accum * 10 + d, wide enough that the overflow test is a plain compare.
  assign wide  = (a_ext << 3) + (a_ext << 1) + {{clmd_pkg::LENGTH_BITS{1'b0}}, d};

  always_comb begin
    nxt = cur;
    case (cur.phase)
      clmd_pkg::PH_LEAD: begin
        if (clmd_pkg::is_blank(in_byte)) begin
          nxt.phase = clmd_pkg::PH_LEAD;
        end else if (in_byte == clmd_pkg::CHAR_PLUS) begin
          nxt.phase = clmd_pkg::PH_SIGN;
        end else if (in_byte == clmd_pkg::CHAR_MINUS) begin
          nxt.phase    = clmd_pkg::PH_SIGN;
          nxt.negative = 1'b1;
        end else if (dig) begin
          nxt.phase = clmd_pkg::PH_DIGITS;
          nxt.accum = clmd_pkg::LENGTH_BITS'(d);
        end else begin
          nxt.phase = clmd_pkg::PH_BAD;
        end
      end
      clmd_pkg::PH_SIGN: begin
        if (dig) begin
          nxt.phase = clmd_pkg::PH_DIGITS;
          nxt.accum = clmd_pkg::LENGTH_BITS'(d);
        end else begin
          nxt.phase = clmd_pkg::PH_BAD;
        end
      end
      clmd_pkg::PH_DIGITS: begin
        if (dig) begin
          if (wide > {4'd0, clmd_pkg::LENGTH_MAX}) begin
            nxt.phase = clmd_pkg::PH_BAD;
          end else begin
            nxt.accum = wide[clmd_pkg::LENGTH_BITS-1:0];
          end
        end else if (clmd_pkg::is_blank(in_byte)) begin
          nxt.phase = clmd_pkg::PH_TRAIL;
        end else begin
          nxt.phase = clmd_pkg::PH_BAD;
        end
      end
      clmd_pkg::PH_TRAIL: begin
        if (!clmd_pkg::is_blank(in_byte)) begin
          nxt.phase = clmd_pkg::PH_BAD;
        end
      end
      default: begin
        nxt.phase = clmd_pkg::PH_BAD;
      end
    endcase
  end

endmodule

### hw/rtl/content_length_message_deframer_top.sv
// Content-Length deframer: the result item of each accepted byte is registered for output.
// Throughput 1 item per cycle while in_tready is high; all framing state updates in one
// pass per byte, the deepest path being the accum*10+d add and range compare of the parser.
// A two-entry output stage (register plus skid) accepts one more byte while a result waits.
// Reset (rst_n low, synchronous) clears all framing state and the sticky error at once.
// Depends on clmd_pkg, clmd_value and the assertion header.
`timescale 1ns / 1ps

`include "content_length_message_deframer_top_assert.svh"

module content_length_message_deframer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] out_byte, [38:8] largest_body, [39] zero
  output logic [1:0]  out_tuser,  // [0] is_body, [1] framing_error
  output logic        out_tlast   // end_of_message
);

  localparam int LB = clmd_pkg::LENGTH_BITS;

  logic          in_body_r, in_body_nxt;
  logic [1:0]    mark_r, mark_nxt;
  logic [3:0]    key_r, key_nxt;
  logic          key_seen_r, key_seen_nxt;
  clmd_pkg::val_t val_r, val_nxt, val_fed;
  logic [LB-1:0] rem_r, rem_nxt;
  logic [LB-1:0] largest_r, largest_nxt;
  logic          error_r, error_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          skid_valid_r, skid_valid_nxt;
  clmd_pkg::res_t out_data_r, out_data_nxt;
  clmd_pkg::res_t skid_data_r, skid_data_nxt;
  clmd_pkg::res_t res;

  logic          in_fire;
  logic [7:0]    b;
  logic [4:0]    key_w;
  logic [2:0]    mark_w;
  logic          hdr_ok;

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign b         = in_tdata;

  clmd_value u_value (
    .in_byte (b),
    .cur     (val_r),
    .nxt     (val_fed)
  );

  always_comb begin
    in_body_nxt  = in_body_r;
    mark_nxt     = mark_r;
    key_nxt      = key_r;
    key_seen_nxt = key_seen_r;
    val_nxt      = val_r;
    rem_nxt      = rem_r;
    largest_nxt  = largest_r;
    error_nxt    = error_r;
    key_w        = 5'd0;
    mark_w       = 3'd0;
    hdr_ok       = 1'b0;

    res.out_byte       = b;
    res.is_body        = 1'b0;
    res.end_of_message = 1'b0;
    res.framing_error  = 1'b0;
    res.largest_body   = 31'(largest_r);

    if (error_r) begin
      res.out_byte      = 8'd0;
      res.framing_error = 1'b1;
    end else if (in_body_r) begin
      res.is_body = 1'b1;
      rem_nxt     = rem_r - LB'(1);
      if (rem_r == LB'(1)) begin
        // Last body byte: record the length, then start a fresh header.
        res.end_of_message = 1'b1;
        if (val_r.accum > largest_r) begin
          largest_nxt = val_r.accum;
        end
        res.largest_body = 31'(largest_nxt);
        in_body_nxt  = 1'b0;
        mark_nxt     = 2'd0;
        key_nxt      = 4'd0;
        key_seen_nxt = 1'b0;
        val_nxt      = '0;
        rem_nxt      = '0;
      end
    end else begin
      if (key_seen_r) begin
        val_nxt = val_fed;
      end else begin
        if (b == clmd_pkg::KEY_TEXT[key_r]) begin
          key_w = {1'b0, key_r} + 5'd1;
        end else begin
          key_w = (b == clmd_pkg::KEY_TEXT[0]) ? 5'd1 : 5'd0;
        end
        if (key_w == 5'(clmd_pkg::KEY_LEN)) begin
          key_seen_nxt = 1'b1;
          key_nxt      = 4'd0;
        end else begin
          key_nxt = key_w[3:0];
        end
      end

      if (b == clmd_pkg::MARK_TEXT[mark_r]) begin
        mark_w = {1'b0, mark_r} + 3'd1;
      end else begin
        mark_w = (b == clmd_pkg::MARK_TEXT[0]) ? 3'd1 : 3'd0;
      end
      mark_nxt = mark_w[1:0];

      if (mark_w == 3'(clmd_pkg::MARK_LEN)) begin
        // "-0" is accepted since its value is zero.
        hdr_ok = key_seen_nxt &&
                 (val_nxt.phase == clmd_pkg::PH_DIGITS ||
                  val_nxt.phase == clmd_pkg::PH_TRAIL) &&
                 !(val_nxt.negative && (val_nxt.accum != '0));
        if (!hdr_ok) begin
          error_nxt         = 1'b1;
          res.out_byte      = 8'd0;
          res.framing_error = 1'b1;
        end else if (val_nxt.accum == '0) begin
          res.end_of_message = 1'b1;
          in_body_nxt  = 1'b0;
          mark_nxt     = 2'd0;
          key_nxt      = 4'd0;
          key_seen_nxt = 1'b0;
          val_nxt      = '0;
          rem_nxt      = '0;
        end else begin
          in_body_nxt = 1'b1;
          rem_nxt     = val_nxt.accum;
          mark_nxt    = 2'd0;
        end
      end
    end
  end

  // Output register with a skid entry behind it.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt  = skid_valid_r;
      out_data_nxt   = skid_data_r;
      skid_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      if (out_valid_r && !out_tready) begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = res;
      end else begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_body_r    <= 1'b0;
      mark_r       <= 2'd0;
      key_r        <= 4'd0;
      key_seen_r   <= 1'b0;
      val_r        <= '0;
      rem_r        <= '0;
      largest_r    <= '0;
      error_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        in_body_r  <= in_body_nxt;
        mark_r     <= mark_nxt;
        key_r      <= key_nxt;
        key_seen_r <= key_seen_nxt;
        val_r      <= val_nxt;
        rem_r      <= rem_nxt;
        largest_r  <= largest_nxt;
        error_r    <= error_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r.largest_body, out_data_r.out_byte};
  assign out_tuser  = {out_data_r.framing_error, out_data_r.is_body};
  assign out_tlast  = out_data_r.end_of_message;

  `CLMD_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r)
  `CLMD_ASSERT_NEXT(a_error_sticky, error_r, error_r)
  `CLMD_ASSERT_NOW(a_body_has_bytes, in_body_r, rem_r != '0)
  `CLMD_ASSERT_NOW(a_error_item_empty, out_tvalid && out_tuser[1],
                   out_tdata[7:0] == 8'd0 && !out_tlast && !out_tuser[0])

endmodule

### tb/content_length_message_deframer_top_tb.sv
// Self-checking testbench for the Content-Length message deframer top level.
// A scoreboard class predicts every result item from the accepted input bytes.
// Depends on clmd_pkg and content_length_message_deframer_top.
`timescale 1ns / 1ps

module content_length_message_deframer_top_tb;

  localparam int LEN_W = clmd_pkg::LENGTH_BITS;
  localparam int KEY_N = 16;
  localparam bit [8*KEY_N-1:0] HDR_KEY = "Content-Length: ";
  localparam bit [7:0] ASCII_CR = 8'h0D;
  localparam bit [7:0] ASCII_LF = 8'h0A;
  localparam int TOTAL_BYTES = 1150;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    bit [7:0]       data;
    bit             body;
    bit             last;
    bit             ferr;
    bit [LEN_W-1:0] largest;
  } byte_result_t;

  class deframer_scoreboard;
    bit             in_body;
    bit [1:0]       mark_cnt;
    bit [4:0]       key_cnt;
    bit             key_found;
    bit [2:0]       phase;
    bit             negative;
    bit [LEN_W-1:0] accum;
    bit [LEN_W-1:0] remaining;
    bit [LEN_W-1:0] largest;
    bit             stuck;
    byte_result_t   pending_results[$];
    int             errors;

    function new();
      restart_header();
      largest = '0;
      stuck   = 1'b0;
      errors  = 0;
    endfunction

    function void restart_header();
      in_body   = 1'b0;
      mark_cnt  = '0;
      key_cnt   = '0;
      key_found = 1'b0;
      phase     = clmd_pkg::PH_LEAD;
      negative  = 1'b0;
      accum     = '0;
      remaining = '0;
    endfunction

    function bit blank_char(bit [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == ASCII_LF || c == 8'h0B ||
             c == 8'h0C || c == ASCII_CR;
    endfunction

    function bit [7:0] key_char(bit [4:0] p);
      return HDR_KEY[8*(KEY_N-1-int'(p)) +: 8];
    endfunction

    function void feed_value(bit [7:0] c);
      bit        digit;
      bit [31:0] d;
      bit [31:0] room;
      digit = (c >= clmd_pkg::CHAR_ZERO) && (c <= clmd_pkg::CHAR_NINE);
      d = digit ? 32'(c - clmd_pkg::CHAR_ZERO) : 32'd0;
      case (phase)
        clmd_pkg::PH_LEAD: begin
          if (c == clmd_pkg::CHAR_PLUS) phase = clmd_pkg::PH_SIGN;
          else if (c == clmd_pkg::CHAR_MINUS) begin
            negative = 1'b1;
            phase = clmd_pkg::PH_SIGN;
          end else if (digit) begin
            accum = d[LEN_W-1:0];
            phase = clmd_pkg::PH_DIGITS;
          end else if (!blank_char(c)) phase = clmd_pkg::PH_BAD;
        end
        clmd_pkg::PH_SIGN: begin
          if (digit) begin
            accum = d[LEN_W-1:0];
            phase = clmd_pkg::PH_DIGITS;
          end else phase = clmd_pkg::PH_BAD;
        end
        clmd_pkg::PH_DIGITS: begin
          if (digit) begin
            // Refuse the digit if accum * 10 + d would pass the largest length.
            room = ({1'b0, clmd_pkg::LENGTH_MAX} - d) / 10;
            if ({1'b0, accum} > room) phase = clmd_pkg::PH_BAD;
            else accum = LEN_W'(accum * 10 + d[LEN_W-1:0]);
          end else if (blank_char(c)) phase = clmd_pkg::PH_TRAIL;
          else phase = clmd_pkg::PH_BAD;
        end
        clmd_pkg::PH_TRAIL: begin
          if (!blank_char(c)) phase = clmd_pkg::PH_BAD;
        end
        default: phase = clmd_pkg::PH_BAD;
      endcase
    endfunction

    function void note_byte(bit [7:0] c);
      byte_result_t r;
      bit [4:0]     p;
      bit [2:0]     m;
      bit           ok;
      r.data = c;
      r.body = 1'b0;
      r.last = 1'b0;
      r.ferr = 1'b0;
      if (stuck) begin
        r.data = '0;
        r.ferr = 1'b1;
      end else if (in_body) begin
        r.body = 1'b1;
        if (remaining != 0) remaining--;
        if (remaining == 0) begin
          r.last = 1'b1;
          if (accum > largest) largest = accum;
          restart_header();
        end
      end else begin
        if (key_found) feed_value(c);
        else begin
          p = (key_cnt < KEY_N) ? key_cnt : 5'd0;
          if (c == key_char(p)) p++;
          else p = (c == key_char(0)) ? 5'd1 : 5'd0;
          if (p >= KEY_N) begin
            key_found = 1'b1;
            p = '0;
          end
          key_cnt = p;
        end
        m = {1'b0, mark_cnt};
        if (c == (m[0] ? ASCII_LF : ASCII_CR)) m++;
        else m = (c == ASCII_CR) ? 3'd1 : 3'd0;
        mark_cnt = m[1:0];
        if (m >= 4) begin
          ok = key_found &&
               (phase == clmd_pkg::PH_DIGITS || phase == clmd_pkg::PH_TRAIL) &&
               !(negative && accum != 0);
          if (!ok) begin
            stuck  = 1'b1;
            r.data = '0;
            r.ferr = 1'b1;
          end else if (accum == 0) begin
            r.last = 1'b1;
            restart_header();
          end else begin
            in_body   = 1'b1;
            remaining = accum;
            mark_cnt  = '0;
          end
        end
      end
      r.largest = largest;
      pending_results.push_back(r);
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_result(byte_result_t got, bit pad);
      byte_result_t exp;
      if (pending_results.size() == 0) begin
        report($sformatf("result item with nothing expected, byte %h", got.data));
        return;
      end
      exp = pending_results.pop_front();
      if (got.data != exp.data)
        report($sformatf("out_byte %h, expected %h", got.data, exp.data));
      if (got.body != exp.body)
        report($sformatf("is_body %0d, expected %0d", got.body, exp.body));
      if (got.last != exp.last)
        report($sformatf("end_of_message %0d, expected %0d", got.last, exp.last));
      if (got.ferr != exp.ferr)
        report($sformatf("framing_error %0d, expected %0d", got.ferr, exp.ferr));
      if (got.largest != exp.largest)
        report($sformatf("largest_body %0d, expected %0d", got.largest, exp.largest));
      if (pad != 1'b0)
        report("padding bit of out_tdata is set");
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  deframer_scoreboard sb;
  bit [7:0] frame_bytes[$];
  int       sent_count;
  bit       tx_burst;
  bit       rx_burst;
  bit       rx_hold_req;
  int       rx_count;
  int       cycle_cnt;

  content_length_message_deframer_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("content_length_message_deframer_top: mismatch");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_byte(in_tdata);
  end

  always @(posedge clk) begin : out_monitor
    byte_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.data    = out_tdata[7:0];
      got.largest = out_tdata[38:8];
      got.body    = out_tuser[0];
      got.ferr    = out_tuser[1];
      got.last    = out_tlast;
      sb.check_result(got, out_tdata[39]);
    end
  end

  // Receiver: random stalls per item, with burst phases and one long hold-off.
  initial begin : receiver
    int stall;
    bit hold_done;
    out_tready = 1'b0;
    hold_done  = 1'b0;
    rx_count   = 0;
    rx_burst   = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_req && !hold_done) begin
        hold_done = 1'b1;
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      rx_count++;
      if (rx_count % 50 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      stall = rx_burst ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  task automatic send_byte(input bit [7:0] b);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
    frame_bytes.delete();
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic bit [7:0] pick_blank();
    case ($urandom_range(0, 3))
      0:       return 8'h20;
      1:       return 8'h09;
      2:       return 8'h0B;
      default: return 8'h0C;
    endcase
  endfunction

  // Well-formed message: noise header lines, the key somewhere, a valid value,
  // the end marker and a random body.
  task automatic build_good_message(input int min_len);
    int       n_lines;
    int       len;
    bit [7:0] c;
    n_lines = $urandom_range(0, 2);
    for (int l = 0; l < n_lines; l++) begin
      push_text("X-");
      repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
      push_text(": ");
      // Content never holds CR, so no stray end marker can form.
      repeat ($urandom_range(1, 6)) begin
        c = 8'($urandom_range(0, 255));
        if (c == ASCII_CR) c = 8'h2E;
        frame_bytes.push_back(c);
      end
      // A broken start of the key makes the matcher fall back.
      if ($urandom_range(0, 3) == 0) begin
        frame_bytes.push_back(HDR_KEY[8*KEY_N-1 -: 8]);
        for (int k = 1; k < $urandom_range(1, 14); k++)
          frame_bytes.push_back(HDR_KEY[8*(KEY_N-1-k) +: 8]);
        push_text(";");
      end
      push_text("\r\n");
    end
    if ($urandom_range(0, 2) == 0) push_text("X-Len: ");
    push_text("Content-Length: ");
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 4) == 0) frame_bytes.push_back(ASCII_LF);
      else frame_bytes.push_back(pick_blank());
    end
    if ($urandom_range(0, 7) == 0) push_text("\r\n");
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13: len = $urandom_range(0, 12);
      14, 15, 16, 17, 18: len = $urandom_range(13, 60);
      default: len = $urandom_range(100, 300);
    endcase
    if (len < min_len) len = min_len;
    case ($urandom_range(0, 3))
      0: push_text("+");
      1: if (len == 0) push_text("-");
      default: ;
    endcase
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) push_text("0");
    push_text($sformatf("%0d", len));
    repeat ($urandom_range(0, 2)) frame_bytes.push_back(pick_blank());
    push_text("\r\n\r\n");
    repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // The framing error is sticky, so exactly one bad or endless header closes the run.
  task automatic build_final_message();
    case ($urandom_range(0, 7))
      0: push_text("Host: a\r\n\r\n");
      1: push_text("Content-Length: -7\r\n\r\n");
      2: push_text("Content-Length: 2147483648\r\n\r\n");
      3: push_text("X: Content-Length: -2147483648\r\n\r\n");
      4: push_text("Content-Length:  \r\n\r\n");
      5: push_text("Content-Length: +\r\n\r\n");
      6: begin
        if ($urandom_range(0, 1) == 0) push_text("Content-Length: 12x\r\n\r\n");
        else push_text("Content-Length: 3 4\r\n\r\n");
      end
      default: push_text("Content-Length: 2147483647\r\n\r\n");
    endcase
    repeat (12) frame_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  initial begin : stimulus
    int msg_idx;
    sb          = new();
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    rx_hold_req = 1'b0;
    tx_burst    = 1'b0;
    sent_count  = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Negative zero is a valid length and ends the message on the marker.
    push_text("Content-Length: -0\r\n\r\n");
    send_frame();

    msg_idx = 0;
    while (sent_count < TOTAL_BYTES - 60) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      if (msg_idx == 4) begin
        tx_burst    = 1'b1;
        rx_hold_req = 1'b1;
        build_good_message(40);
      end else begin
        if (msg_idx == 9) drain_results();
        build_good_message(0);
      end
      send_frame();
      msg_idx++;
    end

    tx_burst = 1'b0;
    build_final_message();
    send_frame();

    drain_results();
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) sb.report("expected result items never arrived");
    if (sb.errors == 0) $display("content_length_message_deframer_top: match");
    else $display("content_length_message_deframer_top: mismatch");
    $finish;
  end

endmodule
